// ===== src/sph_bcm_pkg.sv =====
// ----------------------------------------------------------------------------
// sph_bcm_pkg
// Shared types and constants of the boundary classifier with mirror search.
// ----------------------------------------------------------------------------
package sph_bcm_pkg;

    // Field widths of the beats and registers
    localparam int COORD_W    = 32;
    localparam int ID_W       = 32;
    localparam int SLOT_W     = 10;
    localparam int TOL_W      = 31;
    localparam int COUNT_W    = 11;
    localparam int CLASS_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Internal signed width: holds 2*bound - x and a window edge around it
    localparam int EXT_W = 36;

    // Parameter defaults
    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int COORD_BITS_DEF    = 32;

    // Register reset values
    localparam logic signed [EXT_W-1:0] LOW_RESET  = 36'sd0;
    localparam logic signed [EXT_W-1:0] HIGH_RESET = 36'sd65536;
    localparam logic [TOL_W-1:0]        TOL_RESET  = 31'd1;

    // Command codes
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOMAIN_LOW     = 2'd0,
        CFG_DOMAIN_HIGH    = 2'd1,
        CFG_TOLERANCE      = 2'd2,
        CFG_PARTICLE_COUNT = 2'd3
    } cfg_idx_t;

    // Result classes
    typedef enum logic [CLASS_W-1:0] {
        CLS_VOID        = 3'd0,
        CLS_INTERIOR    = 3'd1,
        CLS_LEFT_POINT  = 3'd2,
        CLS_RIGHT_POINT = 3'd3,
        CLS_LEFT_GHOST  = 3'd4,
        CLS_RIGHT_GHOST = 3'd5
    } class_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CLASS,
        S_WIN,
        S_SCAN,
        S_OUT
    } state_t;

    // Input beat
    typedef struct packed {
        logic                cmd;
        logic [SLOT_W-1:0]   slot;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        logic [COORD_W-1:0]  pos_z;
        logic [ID_W-1:0]     particle_id;
    } req_item_t;

    // Result beat
    typedef struct packed {
        logic [CLASS_W-1:0]  particle_class;
        logic                mirror_found;
        logic [ID_W-1:0]     mirror_id;
    } rsp_item_t;

endpackage

// ===== src/sph_bcm_req_if.sv =====
// ----------------------------------------------------------------------------
// sph_bcm_req_if
// Valid/ready channel carrying load and classify commands.
// ----------------------------------------------------------------------------
interface sph_bcm_req_if;
    import sph_bcm_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/sph_bcm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sph_bcm_rsp_if
// Valid/ready channel carrying classification results.
// ----------------------------------------------------------------------------
interface sph_bcm_rsp_if;
    import sph_bcm_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/sph_bcm_ram.sv =====
// ----------------------------------------------------------------------------
// sph_bcm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sph_bcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/sph_boundary_class_mirror_top.sv =====
// A load beat is written into the table in the cycle it is accepted, if its slot is below MAX_PARTICLES.
// A classify beat passes through PREP (bounds and windows) and CLASS (class registered), then
// goes to OUT, or for a ghost with a non-zero limit through WIN and SCAN over up to limit slots,
// where limit is particle_count saturated at MAX_PARTICLES; the scan stops at the first match.
// Loads are taken back to back while idle; a query keeps the input closed until its result is registered.
// Reset restores the register defaults and clears the sequencer; table contents are undefined.
// ----------------------------------------------------------------------------
// sph_boundary_class_mirror_top
// Classifies a query position against a 1D domain and, for a ghost, searches
// the loaded particle table for the first particle inside the tolerance window of the mirrored position.
// ----------------------------------------------------------------------------
module sph_boundary_class_mirror_top #(
    parameter int MAX_PARTICLES = sph_bcm_pkg::MAX_PARTICLES_DEF,
    parameter int COORD_BITS    = sph_bcm_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sph_bcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sph_bcm_pkg::CFG_DATA_W-1:0]   cfg_data,
    sph_bcm_req_if.sink                          request,
    sph_bcm_rsp_if.source                        response
);
    import sph_bcm_pkg::*;

    // Coordinate width actually compared, and table geometry
    localparam int CW      = (COORD_BITS > 32) ? 32 : COORD_BITS;
    localparam int AW      = $clog2(MAX_PARTICLES);
    localparam int NW      = ($clog2(MAX_PARTICLES + 1) > COUNT_W) ?
                             $clog2(MAX_PARTICLES + 1) : COUNT_W;
    localparam int ENTRY_W = 3 * CW + ID_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_PARTICLES);
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // Configuration registers
    logic signed [EXT_W-1:0] low_reg;
    logic signed [EXT_W-1:0] high_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic [COUNT_W-1:0]      count_reg;

    // Sequencer and datapath registers
    state_t                  state_reg, state_next;
    logic signed [EXT_W-1:0] x_reg, y_reg, z_reg;
    logic                    sentinel_reg;
    logic signed [EXT_W-1:0] lo_p_reg, lo_m_reg, hi_p_reg, hi_m_reg;
    logic signed [EXT_W-1:0] mir_l_reg, mir_r_reg;
    logic signed [EXT_W-1:0] wy_lo_reg, wy_hi_reg, wz_lo_reg, wz_hi_reg;
    logic signed [EXT_W-1:0] wx_lo_reg, wx_hi_reg;
    class_t                  class_reg;
    logic                    found_reg, found_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic [NW-1:0]           rd_cnt_reg, rd_cnt_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    out_valid_reg, out_valid_next;
    rsp_item_t               out_data_reg;

    // Combinational signals
    logic                    req_fire;
    logic                    out_free;
    logic                    out_load;
    logic                    scan_issue;
    logic                    scan_hit;
    logic                    scan_last;
    logic                    ram_we;
    logic [NW-1:0]           slot_ext;
    logic [NW-1:0]           count_ext;
    logic [NW-1:0]           limit;
    logic signed [EXT_W-1:0] tol_ext;
    logic signed [EXT_W-1:0] mx;
    class_t                  cls_c;
    logic                    is_ghost_c;
    logic [ENTRY_W-1:0]      wr_entry;
    logic [ENTRY_W-1:0]      rd_entry;
    logic signed [EXT_W-1:0] ent_x, ent_y, ent_z;
    logic [ID_W-1:0]         ent_id;
    logic                    match_c;

    // Common terms
    assign req_fire  = request.valid && request.ready;
    assign out_free  = !out_valid_reg || response.ready;
    assign tol_ext   = EXT_W'(tol_reg);
    assign slot_ext  = NW'(request.data.slot);
    assign count_ext = NW'(count_reg);
    assign limit     = (count_ext > MAX_N) ? MAX_N : count_ext;

    // Configuration writes, coordinates sign-extended from the coordinate width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= LOW_RESET;
            high_reg  <= HIGH_RESET;
            tol_reg   <= TOL_RESET;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DOMAIN_LOW:
                    low_reg <= {{(EXT_W-CW){cfg_data[CW-1]}}, cfg_data[CW-1:0]};
                CFG_DOMAIN_HIGH:
                    high_reg <= {{(EXT_W-CW){cfg_data[CW-1]}}, cfg_data[CW-1:0]};
                CFG_TOLERANCE:
                    tol_reg <= cfg_data[TOL_W-1:0];
                CFG_PARTICLE_COUNT:
                    count_reg <= cfg_data[COUNT_W-1:0];
                default:
                    count_reg <= count_reg;
            endcase
        end
    end

    // Particle table: x, y, z and id packed into one entry
    assign wr_entry = {request.data.pos_x[CW-1:0], request.data.pos_y[CW-1:0],
                       request.data.pos_z[CW-1:0], request.data.particle_id};

    sph_bcm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTICLES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_ext[AW-1:0]),
        .wdata (wr_entry),
        .re    (scan_issue),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    // Unpack the entry read back during a scan
    assign ent_x  = {{(EXT_W-CW){rd_entry[ENTRY_W-1]}}, rd_entry[ENTRY_W-1 -: CW]};
    assign ent_y  = {{(EXT_W-CW){rd_entry[2*CW+ID_W-1]}}, rd_entry[2*CW+ID_W-1 -: CW]};
    assign ent_z  = {{(EXT_W-CW){rd_entry[CW+ID_W-1]}}, rd_entry[CW+ID_W-1 -: CW]};
    assign ent_id = rd_entry[ID_W-1:0];

    // Shared window compare: each coordinate strictly inside its tolerance window
    assign match_c = (ent_x > wx_lo_reg) && (ent_x < wx_hi_reg) &&
                     (ent_y > wy_lo_reg) && (ent_y < wy_hi_reg) &&
                     (ent_z > wz_lo_reg) && (ent_z < wz_hi_reg);

    // Class decision against the registered bounds, in priority order
    always_comb
    begin
        if (sentinel_reg)
        begin
            cls_c = CLS_VOID;
        end
        else if (x_reg > lo_p_reg && x_reg < hi_m_reg)
        begin
            cls_c = CLS_INTERIOR;
        end
        else if (x_reg > lo_m_reg && x_reg < lo_p_reg)
        begin
            cls_c = CLS_LEFT_POINT;
        end
        else if (x_reg > hi_m_reg && x_reg < hi_p_reg)
        begin
            cls_c = CLS_RIGHT_POINT;
        end
        else if (x_reg < lo_m_reg)
        begin
            cls_c = CLS_LEFT_GHOST;
        end
        else if (x_reg > hi_p_reg)
        begin
            cls_c = CLS_RIGHT_GHOST;
        end
        else
        begin
            cls_c = CLS_VOID;
        end
    end

    assign is_ghost_c = (cls_c == CLS_LEFT_GHOST) || (cls_c == CLS_RIGHT_GHOST);
    assign mx = (class_reg == CLS_LEFT_GHOST) ? mir_l_reg : mir_r_reg;

    // Scan progress
    assign scan_hit  = rd_pend_reg && match_c;
    assign scan_last = rd_pend_reg && (rd_cnt_reg == limit);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && request.data.cmd == CMD_CLASSIFY)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                if (is_ghost_c && limit != '0)
                begin
                    state_next = S_WIN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_WIN:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        request.ready = 1'b0;
        scan_issue    = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                request.ready = 1'b1;
            end
            S_SCAN:
            begin
                scan_issue = (rd_cnt_reg < limit) && !scan_hit;
            end
            S_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                scan_issue = 1'b0;
            end
        endcase
    end

    assign ram_we = req_fire && request.data.cmd == CMD_LOAD && slot_ext < MAX_N;

    // Control next values
    always_comb
    begin
        found_next     = found_reg;
        id_next        = id_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_pend_next   = scan_issue;
        out_valid_next = out_valid_reg;

        if (req_fire)
        begin
            found_next = 1'b0;
            id_next    = '0;
        end
        if (state_reg == S_WIN)
        begin
            rd_cnt_next = '0;
        end
        if (scan_issue)
        begin
            rd_cnt_next = rd_cnt_reg + NW'(1);
        end
        if (state_reg == S_SCAN && scan_hit)
        begin
            found_next = 1'b1;
            id_next    = ent_id;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            found_reg     <= 1'b0;
            id_reg        <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            id_reg        <= id_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Query capture, bound and window arithmetic, result register
    always_ff @(posedge clk)
    begin
        if (req_fire && request.data.cmd == CMD_CLASSIFY)
        begin
            x_reg <= {{(EXT_W-CW){request.data.pos_x[CW-1]}}, request.data.pos_x[CW-1:0]};
            y_reg <= {{(EXT_W-CW){request.data.pos_y[CW-1]}}, request.data.pos_y[CW-1:0]};
            z_reg <= {{(EXT_W-CW){request.data.pos_z[CW-1]}}, request.data.pos_z[CW-1:0]};
            sentinel_reg <= (request.data.pos_x[CW-1:0] == COORD_MIN);
        end
        if (state_reg == S_PREP)
        begin
            lo_p_reg  <= low_reg + tol_ext;
            lo_m_reg  <= low_reg - tol_ext;
            hi_p_reg  <= high_reg + tol_ext;
            hi_m_reg  <= high_reg - tol_ext;
            mir_l_reg <= (low_reg <<< 1) - x_reg;
            mir_r_reg <= (high_reg <<< 1) - x_reg;
            wy_lo_reg <= y_reg - tol_ext;
            wy_hi_reg <= y_reg + tol_ext;
            wz_lo_reg <= z_reg - tol_ext;
            wz_hi_reg <= z_reg + tol_ext;
        end
        if (state_reg == S_CLASS)
        begin
            class_reg <= cls_c;
        end
        if (state_reg == S_WIN)
        begin
            wx_lo_reg <= mx - tol_ext;
            wx_hi_reg <= mx + tol_ext;
        end
        if (out_load)
        begin
            out_data_reg.particle_class <= class_reg;
            out_data_reg.mirror_found   <= found_reg;
            out_data_reg.mirror_id      <= found_reg ? id_reg : '0;
        end
    end

    assign response.valid = out_valid_reg;
    assign response.data  = out_data_reg;

    // A read is only issued for a slot below the scan limit.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_issue |-> rd_cnt_reg < limit)
        else $error("scan read beyond the particle limit");

    // A result with no ghost class never reports a mirror.
    a_no_mirror_off_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && !(response.data.particle_class == CLS_LEFT_GHOST ||
                            response.data.particle_class == CLS_RIGHT_GHOST)
        |-> !response.data.mirror_found)
        else $error("mirror reported for a non-ghost class");

    // A missing mirror gives id zero.
    a_id_zero_when_missing: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && !response.data.mirror_found |-> response.data.mirror_id == '0)
        else $error("non-zero mirror id without a mirror");

    // A classify beat closes the input until its result is registered.
    a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && request.data.cmd == CMD_CLASSIFY |=> !request.ready)
        else $error("input open while a query is in progress");

    // The result register is only loaded when leaving the output state.
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");
endmodule
